// ----- hdl/sgdw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgdw_pkg
// Shared types and constants of the SGD update unit with strided tensor walk.
// ----------------------------------------------------------------------------
package sgdw_pkg;

  localparam int MAX_DIMS    = 3;
  localparam int OFFSET_BITS = 20;
  localparam int SIZE_BITS   = 12;
  localparam int DIM_BITS    = $clog2(MAX_DIMS + 1);

  localparam int RATE_BITS   = 16;
  localparam int DCOUNT_BITS = 2;
  localparam int SIZE_FIELD  = SIZE_BITS + 1;
  localparam int INDEX_BITS  = 4;
  localparam int DATA_BITS   = 20;

  localparam logic [RATE_BITS-1:0]   RATE_RESET   = 16'd655;
  localparam logic [DCOUNT_BITS-1:0] DCOUNT_RESET = 2'd1;
  localparam logic [SIZE_FIELD-1:0]  SIZE_RESET   = 13'd1;

  // Register indexes of the configuration port
  typedef enum logic [INDEX_BITS-1:0] {
    REG_RATE          = 4'd0,
    REG_DIM_COUNT     = 4'd1,
    REG_SIZE_INNER    = 4'd2,
    REG_SIZE_MIDDLE   = 4'd3,
    REG_SIZE_OUTER    = 4'd4,
    REG_STRIDE_INNER  = 4'd5,
    REG_STRIDE_MIDDLE = 4'd6,
    REG_STRIDE_OUTER  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
  } item_t;

  typedef struct packed {
    logic signed [31:0]     new_weight;
    logic [OFFSET_BITS-1:0] element_offset;
    logic                   last_element;
  } result_t;

  // Walk information that travels alongside an item
  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic                   last;
  } tag_t;

  // Settings derived from the configuration registers
  typedef struct packed {
    logic [RATE_BITS-1:0]                       rate;
    logic [DIM_BITS-1:0]                        ndims;
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0]         lim;
    logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]       stride;
    logic [MAX_DIMS:0][OFFSET_BITS-1:0]         cum;
  } walk_cfg_t;

endpackage
`default_nettype wire

// ----- hdl/sgdw_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgdw_cfg
// Configuration registers and the registered terms derived from them.
// ----------------------------------------------------------------------------
module sgdw_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [sgdw_pkg::INDEX_BITS-1:0] wr_index,
  input  wire logic [sgdw_pkg::DATA_BITS-1:0]  wr_data,
  output sgdw_pkg::walk_cfg_t                 walk_cfg,
  output logic                                settled
);
  import sgdw_pkg::*;

  logic [RATE_BITS-1:0]                 rate;
  logic [DCOUNT_BITS-1:0]               dim_count;
  logic [MAX_DIMS-1:0][SIZE_FIELD-1:0]  size_reg;
  logic [MAX_DIMS-1:0][OFFSET_BITS-1:0] stride_reg;

  logic [MAX_DIMS-1:0][SIZE_BITS-1:0]   lim;
  logic [MAX_DIMS-1:0][OFFSET_BITS-1:0] back;
  logic [MAX_DIMS:0][OFFSET_BITS-1:0]   cum;
  logic [DIM_BITS-1:0]                  ndims;
  logic [1:0]                           settle_cnt;

  logic [MAX_DIMS-1:0][SIZE_BITS-1:0]   lim_next;
  logic [DIM_BITS-1:0]                  ndims_next;
  logic [MAX_DIMS:0][OFFSET_BITS-1:0]   cum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= RATE_RESET;
      dim_count  <= DCOUNT_RESET;
      size_reg   <= {MAX_DIMS{SIZE_RESET}};
      stride_reg <= (MAX_DIMS*OFFSET_BITS)'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RATE:          rate          <= wr_data[RATE_BITS-1:0];
        REG_DIM_COUNT:     dim_count     <= wr_data[DCOUNT_BITS-1:0];
        REG_SIZE_INNER:    size_reg[0]   <= wr_data[SIZE_FIELD-1:0];
        REG_SIZE_MIDDLE:   size_reg[1]   <= wr_data[SIZE_FIELD-1:0];
        REG_SIZE_OUTER:    size_reg[2]   <= wr_data[SIZE_FIELD-1:0];
        REG_STRIDE_INNER:  stride_reg[0] <= wr_data[OFFSET_BITS-1:0];
        REG_STRIDE_MIDDLE: stride_reg[1] <= wr_data[OFFSET_BITS-1:0];
        REG_STRIDE_OUTER:  stride_reg[2] <= wr_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Last index of each dimension: size zero acts as one, oversize is capped
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (size_reg[d] == '0) begin
        lim_next[d] = '0;
      end else if (size_reg[d][SIZE_BITS]) begin
        lim_next[d] = '1;
      end else begin
        lim_next[d] = size_reg[d][SIZE_BITS-1:0] - SIZE_BITS'(1);
      end
    end
    if (dim_count == '0) begin
      ndims_next = DIM_BITS'(1);
    end else if (DIM_BITS'(dim_count) > DIM_BITS'(MAX_DIMS)) begin
      ndims_next = DIM_BITS'(MAX_DIMS);
    end else begin
      ndims_next = DIM_BITS'(dim_count);
    end
    cum_next[0] = '0;
    for (int d = 1; d <= MAX_DIMS; d++) begin
      cum_next[d] = cum_next[d-1] + back[d-1];
    end
  end

  // Stage one: wrap-back amount per dimension; stage two: running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      lim   <= '0;
      back  <= '0;
      cum   <= '0;
      ndims <= DIM_BITS'(1);
    end else begin
      lim   <= lim_next;
      ndims <= ndims_next;
      for (int d = 0; d < MAX_DIMS; d++) begin
        back[d] <= OFFSET_BITS'(stride_reg[d] * lim_next[d]);
      end
      cum <= cum_next;
    end
  end

  // Hold off items until both derived stages have seen the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= '0;
    end else if (wr_en) begin
      settle_cnt <= 2'd2;
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  assign settled         = (settle_cnt == '0);
  assign walk_cfg.rate   = rate;
  assign walk_cfg.ndims  = ndims;
  assign walk_cfg.lim    = lim;
  assign walk_cfg.stride = stride_reg;
  assign walk_cfg.cum    = cum;

endmodule
`default_nettype wire

// ----- hdl/sgdw_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgdw_walk
// Per-dimension index counters and the running storage offset.
// ----------------------------------------------------------------------------
module sgdw_walk (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire sgdw_pkg::walk_cfg_t walk_cfg,
  output sgdw_pkg::tag_t          tag
);
  import sgdw_pkg::*;

  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] dim_index;
  logic [OFFSET_BITS-1:0]             current_offset;

  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] dim_index_next;
  logic [OFFSET_BITS-1:0]             current_offset_next;
  logic [OFFSET_BITS-1:0]             sel_stride;
  logic [DIM_BITS-1:0]                wraps;
  logic                               carry;

  // Carry ripples outward through wrapping dimensions; first non-wrap stops it
  always_comb begin
    dim_index_next = dim_index;
    sel_stride     = '0;
    wraps          = '0;
    carry          = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (carry && (DIM_BITS'(d) < walk_cfg.ndims)) begin
        if (dim_index[d] >= walk_cfg.lim[d]) begin
          dim_index_next[d] = '0;
          wraps             = wraps + DIM_BITS'(1);
        end else begin
          dim_index_next[d] = dim_index[d] + SIZE_BITS'(1);
          sel_stride        = walk_cfg.stride[d];
          carry             = 1'b0;
        end
      end
    end
    current_offset_next = current_offset - walk_cfg.cum[wraps] + sel_stride;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_index      <= '0;
      current_offset <= '0;
    end else if (step) begin
      dim_index      <= dim_index_next;
      current_offset <= current_offset_next;
    end
  end

  assign tag.offset = current_offset;
  assign tag.last   = carry;

endmodule
`default_nettype wire

// ----- hdl/sgdw_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgdw_update
// Three-stage weight update pipeline: multiply, subtract and saturate, output.
// ----------------------------------------------------------------------------
module sgdw_update (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [sgdw_pkg::RATE_BITS-1:0] rate,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire sgdw_pkg::item_t                item,
  input  wire sgdw_pkg::tag_t                 item_tag,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output sgdw_pkg::result_t                   result
);
  import sgdw_pkg::*;

  logic               a_valid;
  item_t              a_item;
  tag_t               a_tag;
  logic               b_valid;
  logic signed [31:0] b_weight;
  logic signed [32:0] b_step;
  tag_t               b_tag;

  logic               out_en;
  logic               b_en;
  logic               a_en;
  logic signed [48:0] product;
  logic [33:0]        diff;
  logic signed [31:0] sat_weight;

  assign out_en     = !result_valid || result_ready;
  assign b_en       = !b_valid || out_en;
  assign a_en       = !a_valid || b_en;
  assign item_ready = a_en;

  assign product = $signed(a_item.gradient) * $signed({1'b0, rate});

  // Arithmetic shift of the product leaves the floor; saturate the difference
  assign diff = {{2{b_weight[31]}}, b_weight} - {b_step[32], b_step};

  always_comb begin
    if (diff[33] && !(diff[32] && diff[31])) begin
      sat_weight = 32'sh8000_0000;
    end else if (!diff[33] && (diff[32] || diff[31])) begin
      sat_weight = 32'sh7FFF_FFFF;
    end else begin
      sat_weight = $signed(diff[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= item_valid;
      end
      if (b_en) begin
        b_valid <= a_valid;
      end
      if (out_en) begin
        result_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_item <= item;
      a_tag  <= item_tag;
    end
    if (b_en) begin
      b_weight <= a_item.weight;
      b_step   <= product[48:16];
      b_tag    <= a_tag;
    end
    if (out_en) begin
      result.new_weight     <= sat_weight;
      result.element_offset <= b_tag.offset;
      result.last_element   <= b_tag.last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgd_update_strided_walk_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_update_strided_walk_unit
// SGD weight update with strided storage offset generation for one tensor.
// ----------------------------------------------------------------------------
// Each item passes the a-stage, b-stage and result registers before its
// result is valid. Throughput: one item per cycle while the result side keeps
// taking transfers and no write is settling. After a configuration write,
// items are held off while the registered wrap-back terms (stride times last
// index) and their running sums settle. Reset: configuration takes its reset
// values, index counters and offset clear to zero, and the pipeline empties.
// ----------------------------------------------------------------------------
module sgd_update_strided_walk_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item channel
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire sgdw_pkg::item_t                 item,
  // result channel
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output sgdw_pkg::result_t                    result,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sgdw_pkg::INDEX_BITS-1:0] cfg_index,
  input  wire logic [sgdw_pkg::DATA_BITS-1:0]  cfg_data
);
  import sgdw_pkg::*;

  walk_cfg_t walk_cfg;
  tag_t      walk_tag;
  logic      cfg_settled;
  logic      upd_ready;
  logic      item_take;

  // Configuration writes are always taken; unknown indexes are dropped inside
  assign cfg_ready = 1'b1;

  sgdw_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .walk_cfg (walk_cfg),
    .settled  (cfg_settled)
  );

  // Accept an item only once the derived walk terms are current and the
  // first pipeline stage can take it
  assign item_ready = upd_ready && cfg_settled;
  assign item_take  = item_valid && item_ready;

  // The walk reports this element's offset and last flag combinationally,
  // then advances its counters on the same transfer
  sgdw_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .step     (item_take),
    .walk_cfg (walk_cfg),
    .tag      (walk_tag)
  );

  sgdw_update u_update (
    .clk          (clk),
    .rst          (rst),
    .rate         (walk_cfg.rate),
    .item_valid   (item_valid && cfg_settled),
    .item_ready   (upd_ready),
    .item         (item),
    .item_tag     (walk_tag),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SGD update unit with strided tensor walk.
// A short table of directed transfers comes first (reset settings, weight and
// gradient extremes, register masking, a full three-dimensional walk and a
// size change part-way through a walk). Random phases follow, each opening
// with fresh register settings written while the unit is idle. Every accepted
// item is run through a local model of the update and the walk. Each result
// transfer is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

  import sgdw_pkg::*;

  localparam int RANDOM_ITEMS   = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int REG_COUNT      = 8;
  // Any index at or past REG_COUNT is outside the register file
  localparam logic [INDEX_BITS-1:0] REG_UNUSED = 4'hF;

  localparam logic signed [63:0] WEIGHT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WEIGHT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: a register write or an item, with the
  // result typed in where it is plain to see
  typedef struct {
    row_kind_t             kind;
    logic [INDEX_BITS-1:0] idx;
    logic [DATA_BITS-1:0]  data;
    item_t                 it;
    bit                    typed;
    result_t               res;
  } stim_row_t;

  // Clock, reset and ports; every input starts at a known value
  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    cfg_valid    = 1'b0;
  logic    cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index = '0;
  logic [DATA_BITS-1:0]  cfg_data  = '0;

  // Shadow registers and walk state of the model
  logic [RATE_BITS-1:0]   rate_q;
  logic [DCOUNT_BITS-1:0] dims_q;
  logic [SIZE_FIELD-1:0]  size_q   [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_q [MAX_DIMS];
  logic [SIZE_BITS-1:0]   index_q  [MAX_DIMS];
  logic [OFFSET_BITS-1:0] offset_q;

  result_t   pending_updates [$];
  stim_row_t stim_rows [$];
  result_t   oldest;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;

  sgd_update_strided_walk_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the unit
  // --------------------------------------------------------------------------

  function automatic void model_reset();
    rate_q   = RATE_RESET;
    dims_q   = DCOUNT_RESET;
    offset_q = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      size_q[d]  = SIZE_RESET;
      index_q[d] = '0;
    end
    stride_q[0] = 20'd1;
    stride_q[1] = '0;
    stride_q[2] = '0;
  endfunction

  // Mask the write data to the register width; drop writes past the list
  function automatic void model_write(input logic [INDEX_BITS-1:0] idx,
                                      input logic [DATA_BITS-1:0] data);
    case (idx)
      REG_RATE:          rate_q      = data[RATE_BITS-1:0];
      REG_DIM_COUNT:     dims_q      = data[DCOUNT_BITS-1:0];
      REG_SIZE_INNER:    size_q[0]   = data[SIZE_FIELD-1:0];
      REG_SIZE_MIDDLE:   size_q[1]   = data[SIZE_FIELD-1:0];
      REG_SIZE_OUTER:    size_q[2]   = data[SIZE_FIELD-1:0];
      REG_STRIDE_INNER:  stride_q[0] = data[OFFSET_BITS-1:0];
      REG_STRIDE_MIDDLE: stride_q[1] = data[OFFSET_BITS-1:0];
      REG_STRIDE_OUTER:  stride_q[2] = data[OFFSET_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Work out the updated weight, then advance the walk by one element
  function automatic result_t predict_update(input item_t it);
    logic signed [63:0] prod;
    logic signed [63:0] nw;
    logic [63:0]        back;
    int                 lim;
    int                 ndims;
    bit                 carry;
    result_t            r;
    // Floor of rate*gradient/2^16 is an arithmetic shift of the exact product
    prod = $signed(it.gradient) * $signed({1'b0, rate_q});
    nw   = $signed(it.weight) - (prod >>> 16);
    if (nw > WEIGHT_MAX) nw = WEIGHT_MAX;
    else if (nw < WEIGHT_MIN) nw = WEIGHT_MIN;
    r.new_weight     = nw[31:0];
    r.element_offset = offset_q;
    r.last_element   = 1'b1;
    // A dimension count of zero counts as one
    ndims = (dims_q == '0) ? 1 : int'(dims_q);
    if (ndims > MAX_DIMS) ndims = MAX_DIMS;
    carry = 1'b1;
    for (int d = 0; d < ndims; d++) begin
      if (carry) begin
        lim = (size_q[d] == '0) ? 1 : int'(size_q[d]);
        if (lim > (1 << SIZE_BITS)) lim = 1 << SIZE_BITS;
        // An index at or past its last position wraps, even after a shrink
        if (int'(index_q[d]) + 1 >= lim) begin
          index_q[d] = '0;
          back       = 64'(stride_q[d]) * 64'(lim - 1);
          offset_q   = offset_q - back[OFFSET_BITS-1:0];
        end else begin
          index_q[d]     = index_q[d] + SIZE_BITS'(1);
          offset_q       = offset_q + stride_q[d];
          carry          = 1'b0;
          r.last_element = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------

  function automatic void add_cfg(input logic [INDEX_BITS-1:0] idx,
                                  input logic [DATA_BITS-1:0] data);
    stim_row_t row;
    row       = '{kind: ROW_CFG, default: '0};
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = data;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic [31:0] w, input logic [31:0] g);
    stim_row_t row;
    row             = '{kind: ROW_ITEM, default: '0};
    row.kind        = ROW_ITEM;
    row.it.weight   = w;
    row.it.gradient = g;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic [31:0] w, input logic [31:0] g,
                                    input logic [31:0] nw,
                                    input logic [OFFSET_BITS-1:0] off,
                                    input logic last);
    add_item(w, g);
    stim_rows[$].typed              = 1'b1;
    stim_rows[$].res.new_weight     = nw;
    stim_rows[$].res.element_offset = off;
    stim_rows[$].res.last_element   = last;
  endfunction

  function automatic void build_directed();
    // Reset settings: rate 655, one dimension of size one, so every element
    // sits at offset zero and closes the walk
    add_known(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h0, 1'b1);
    add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'h0, 1'b1);
    add_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h0, 1'b1);
    add_known(32'h0001_0000, 32'h0001_0000, 32'h0000_FD71, 20'h0, 1'b1);
    // Small negative step rounds towards minus infinity
    add_known(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 20'h0, 1'b1);
    add_known(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 20'h0, 1'b1);
    // Full rate, dimension count zero, largest stride: the offset wraps
    add_cfg(REG_RATE, 20'h0FFFF);
    add_cfg(REG_DIM_COUNT, 20'h0);
    add_cfg(REG_SIZE_INNER, 20'd3);
    add_cfg(REG_STRIDE_INNER, 20'hFFFFF);
    add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'h00000, 1'b0);
    add_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 1'b0);
    add_known(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'hFFFFE, 1'b1);
    // Zero rate passes weights through; a 2x2x2 cube, count written with
    // spare upper bits set, plus a write past the register list
    add_cfg(REG_RATE, 20'h0);
    add_cfg(REG_DIM_COUNT, 20'hFFFFF);
    add_cfg(REG_SIZE_INNER, 20'd2);
    add_cfg(REG_SIZE_MIDDLE, 20'd2);
    add_cfg(REG_SIZE_OUTER, 20'd2);
    add_cfg(REG_STRIDE_INNER, 20'h1);
    add_cfg(REG_STRIDE_MIDDLE, 20'h10);
    add_cfg(REG_STRIDE_OUTER, 20'h100);
    add_cfg(REG_UNUSED, 20'hFFFFF);
    add_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h000, 1'b0);
    add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'h001, 1'b0);
    add_known(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 20'h010, 1'b0);
    add_known(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 20'h011, 1'b0);
    add_known(32'h1234_5678, 32'h5555_5555, 32'h1234_5678, 20'h100, 1'b0);
    add_known(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 20'h101, 1'b0);
    add_known(32'h5555_5555, 32'h1234_5678, 32'h5555_5555, 20'h110, 1'b0);
    add_known(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h111, 1'b1);
    // Shrink the inner size part-way through a walk: the stale index wraps
    add_cfg(REG_RATE, 20'h08000);
    add_cfg(REG_DIM_COUNT, 20'd2);
    add_cfg(REG_SIZE_INNER, 20'd4);
    add_cfg(REG_SIZE_MIDDLE, 20'd3);
    add_item(32'h0001_0000, 32'h0002_0000);
    add_item(32'hFFFF_0000, 32'hFFFE_0000);
    add_cfg(REG_SIZE_INNER, 20'd2);
    add_item(32'h0000_8000, 32'h0000_0001);
    add_item(32'h7FFF_0000, 32'h8000_0000);
    add_item(32'h8000_FFFF, 32'h7FFF_FFFF);
  endfunction

  // --------------------------------------------------------------------------
  // Random values
  // --------------------------------------------------------------------------

  // Mix extremes, small magnitudes and full-range words
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic item_t random_update();
    item_t it;
    it.weight   = random_word();
    it.gradient = random_word();
    return it;
  endfunction

  // Mostly small sizes, so walks wrap often; now and then an extreme
  function automatic logic [DATA_BITS-1:0] random_setting(input int r);
    case (cfg_reg_t'(r))
      REG_RATE:
        case ($urandom_range(0, 3))
          0:       return 20'h0;
          1:       return 20'h0FFFF;
          2:       return 20'(RATE_RESET);
          default: return 20'($urandom);
        endcase
      REG_DIM_COUNT:
        return $urandom_range(0, 1) ? 20'($urandom_range(0, 3)) : 20'($urandom);
      REG_SIZE_INNER, REG_SIZE_MIDDLE, REG_SIZE_OUTER:
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0:       return 20'd0;
            1:       return 20'd4096;
            2:       return 20'd8191;
            default: return 20'($urandom);
          endcase
        end else begin
          return 20'($urandom_range(1, 6));
        end
      default:
        case ($urandom_range(0, 3))
          0:       return 20'h0;
          1:       return 20'hFFFFF;
          2:       return 20'($urandom_range(1, 16));
          default: return 20'($urandom);
        endcase
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one item, idling first at random, and record what it should give.
  // Returns at the edge of the transfer so the next item can follow at once.
  task automatic send_update(input item_t it, input bit typed = 1'b0,
                             input result_t typed_res = '0);
    result_t predicted;
    while (!steady && $urandom_range(99) < 32) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predicted = predict_update(it);
    pending_updates.push_back(typed ? typed_res : predicted);
  endtask

  // Hold the item side until every expected result has been taken
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  // Leave cfg_valid high on return; the caller drops it after the last write
  task automatic cfg_write(input logic [INDEX_BITS-1:0] idx,
                           input logic [DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, data);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and checking of every transfer
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", result));
      end else begin
        oldest = pending_updates.pop_front();
        if (result.new_weight !== oldest.new_weight)
          report_mismatch($sformatf("new_weight %h, want %h",
                                    result.new_weight, oldest.new_weight));
        if (result.element_offset !== oldest.element_offset)
          report_mismatch($sformatf("element_offset %h, want %h",
                                    result.element_offset, oldest.element_offset));
        if (result.last_element !== oldest.last_element)
          report_mismatch($sformatf("last_element %b, want %b",
                                    result.last_element, oldest.last_element));
      end
    end
    result_ready <= steady || ($urandom_range(99) >= 32);
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    bit cfg_open;
    int sent;
    int count;
    model_reset();
    build_directed();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; register writes wait for an idle unit
    cfg_open = 1'b0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) settle();
        cfg_write(stim_rows[i].idx, stim_rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_update(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].res);
      end
    end

    // Random phases: drain, rewrite some registers (all of them the first
    // time), then stream a burst of items. Walk state carries over, so size
    // changes often land part-way through a walk.
    sent = 0;
    for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
      settle();
      steady = (phase >= 6 && phase < 10);
      for (int r = 0; r < REG_COUNT; r++)
        if (phase == 0 || $urandom_range(0, 1))
          cfg_write(INDEX_BITS'(r), random_setting(r));
      if ($urandom_range(0, 3) == 0)
        cfg_write(INDEX_BITS'($urandom_range(REG_COUNT, 15)), 20'($urandom));
      cfg_valid <= 1'b0;
      count = $urandom_range(10, 60);
      repeat (count) begin
        send_update(random_update());
        sent++;
      end
    end
    steady = 1'b0;

    // Drain, then keep watching for any stray result before the verdict
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
